[hw/rtl/polyline_vertex_reducer_defines.svh]
// Assertion macros shared by the polyline vertex reducer RTL.
`ifndef POLYLINE_VERTEX_REDUCER_DEFINES_SVH
`define POLYLINE_VERTEX_REDUCER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PVR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pvr assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PVR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pvr assertion failed");

`endif

[hw/rtl/pvr_pkg.sv]
// Types, constants and the micro-program of the polyline vertex reducer.
package pvr_pkg;

    localparam int C_ID_W      = 24;
    localparam int C_COORD_W   = 32;
    localparam int C_DIFF_W    = C_COORD_W + 1;
    localparam int C_THR_W     = 31;
    localparam int C_COS_W     = 16;
    localparam int C_CFG_W     = 31;
    localparam int C_CFG_IDX_W = 1;
    localparam int C_WIDE_W    = 192;
    localparam int C_LIMB_W    = 32;
    localparam int C_LIMB_SH   = $clog2(C_LIMB_W);
    localparam int C_MAG_LIMBS = 5;
    localparam int C_MAG_W     = C_MAG_LIMBS * C_LIMB_W;
    localparam int C_SLOTS     = 21;
    localparam int C_SLOT_AW   = 5;
    localparam int C_PC_W      = 6;
    localparam int C_LHS_SH    = 30;

    localparam logic [C_CFG_IDX_W-1:0] CFG_DIST = 1'b0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_COS  = 1'b1;

    localparam logic [C_THR_W-1:0] C_DIST_RST = 31'd65536;
    localparam logic [C_COS_W-1:0] C_COS_RST  = 16'h81EC; // -32276

    typedef logic [C_SLOT_AW-1:0] t_slot;

    localparam t_slot SL_DX  = 5'd0;
    localparam t_slot SL_DY  = 5'd1;
    localparam t_slot SL_EX  = 5'd2;
    localparam t_slot SL_EY  = 5'd3;
    localparam t_slot SL_FX  = 5'd4;
    localparam t_slot SL_FY  = 5'd5;
    localparam t_slot SL_THR = 5'd6;
    localparam t_slot SL_CL  = 5'd7;
    localparam t_slot SL_DD  = 5'd8;
    localparam t_slot SL_ED  = 5'd9;
    localparam t_slot SL_CR  = 5'd10;
    localparam t_slot SL_CR2 = 5'd11;
    localparam t_slot SL_T2  = 5'd12;
    localparam t_slot SL_TDD = 5'd13;
    localparam t_slot SL_N1  = 5'd14;
    localparam t_slot SL_N2  = 5'd15;
    localparam t_slot SL_P   = 5'd16;
    localparam t_slot SL_Q   = 5'd17;
    localparam t_slot SL_L2  = 5'd18;
    localparam t_slot SL_RHS = 5'd19;
    localparam t_slot SL_LHS = 5'd20;

    typedef enum logic [3:0] {
        OP_LDIN, OP_MUL, OP_ST, OP_STSH, OP_ZERO, OP_NEG, OP_GT, OP_PSIG, OP_COS
    } t_op;

    typedef struct packed {
        t_op        op;
        t_slot      a;
        t_slot      b;
        logic [2:0] na;
        logic [2:0] nb;
        logic       clr;
        logic       sub;
    } t_uop;

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_EMIT} t_state;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_FETCH, SQ_EXEC, SQ_LIMB, SQ_DRAIN
    } t_seq_state;

    typedef struct packed {
        logic [C_COORD_W-1:0] ax;
        logic [C_COORD_W-1:0] ay;
        logic [C_COORD_W-1:0] cx;
        logic [C_COORD_W-1:0] cy;
        logic [C_COORD_W-1:0] bx;
        logic [C_COORD_W-1:0] by;
    } t_geom;

    typedef struct packed {
        logic done;
        logic keep;
    } t_seq_stat;

    typedef struct packed {
        logic                clr;
        logic                mul;
        logic                sub;
        logic [C_LIMB_W-1:0] a;
        logic [C_LIMB_W-1:0] b;
        logic [2:0]          pos;
    } t_mac_ctrl;

    function automatic t_uop f_uop(t_op op, t_slot a, t_slot b, logic [2:0] na,
                                   logic [2:0] nb, logic clr, logic sub);
        t_uop u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.na  = na;
        u.nb  = nb;
        u.clr = clr;
        u.sub = sub;
        return u;
    endfunction

    // Magnitude limb counts: differences 2, squared sums 3, products of two sums 5.
    function automatic t_uop f_prog(logic [C_PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = f_uop(OP_LDIN, SL_DX,  SL_DX,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd1:  u = f_uop(OP_LDIN, SL_DY,  SL_DY,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd2:  u = f_uop(OP_LDIN, SL_EX,  SL_EX,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd3:  u = f_uop(OP_LDIN, SL_EY,  SL_EY,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd4:  u = f_uop(OP_LDIN, SL_FX,  SL_FX,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd5:  u = f_uop(OP_LDIN, SL_FY,  SL_FY,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd6:  u = f_uop(OP_LDIN, SL_THR, SL_THR, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd7:  u = f_uop(OP_LDIN, SL_CL,  SL_CL,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd8:  u = f_uop(OP_MUL,  SL_DX,  SL_DX,  3'd2, 3'd2, 1'b1, 1'b0);
            6'd9:  u = f_uop(OP_MUL,  SL_DY,  SL_DY,  3'd2, 3'd2, 1'b0, 1'b0);
            6'd10: u = f_uop(OP_ST,   SL_DD,  SL_DD,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd11: u = f_uop(OP_ZERO, SL_DD,  SL_DD,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd12: u = f_uop(OP_MUL,  SL_EX,  SL_DX,  3'd2, 3'd2, 1'b1, 1'b0);
            6'd13: u = f_uop(OP_MUL,  SL_EY,  SL_DY,  3'd2, 3'd2, 1'b0, 1'b0);
            6'd14: u = f_uop(OP_ST,   SL_ED,  SL_ED,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd15: u = f_uop(OP_NEG,  SL_ED,  SL_ED,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd16: u = f_uop(OP_GT,   SL_ED,  SL_DD,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd17: u = f_uop(OP_MUL,  SL_DX,  SL_EY,  3'd2, 3'd2, 1'b1, 1'b0);
            6'd18: u = f_uop(OP_MUL,  SL_DY,  SL_EX,  3'd2, 3'd2, 1'b0, 1'b1);
            6'd19: u = f_uop(OP_ST,   SL_CR,  SL_CR,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd20: u = f_uop(OP_MUL,  SL_CR,  SL_CR,  3'd3, 3'd3, 1'b1, 1'b0);
            6'd21: u = f_uop(OP_ST,   SL_CR2, SL_CR2, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd22: u = f_uop(OP_MUL,  SL_THR, SL_THR, 3'd1, 3'd1, 1'b1, 1'b0);
            6'd23: u = f_uop(OP_ST,   SL_T2,  SL_T2,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd24: u = f_uop(OP_MUL,  SL_T2,  SL_DD,  3'd2, 3'd3, 1'b1, 1'b0);
            6'd25: u = f_uop(OP_ST,   SL_TDD, SL_TDD, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd26: u = f_uop(OP_GT,   SL_CR2, SL_TDD, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd27: u = f_uop(OP_MUL,  SL_EX,  SL_EX,  3'd2, 3'd2, 1'b1, 1'b0);
            6'd28: u = f_uop(OP_MUL,  SL_EY,  SL_EY,  3'd2, 3'd2, 1'b0, 1'b0);
            6'd29: u = f_uop(OP_ST,   SL_N1,  SL_N1,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd30: u = f_uop(OP_ZERO, SL_N1,  SL_N1,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd31: u = f_uop(OP_MUL,  SL_FX,  SL_FX,  3'd2, 3'd2, 1'b1, 1'b0);
            6'd32: u = f_uop(OP_MUL,  SL_FY,  SL_FY,  3'd2, 3'd2, 1'b0, 1'b0);
            6'd33: u = f_uop(OP_ST,   SL_N2,  SL_N2,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd34: u = f_uop(OP_ZERO, SL_N2,  SL_N2,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd35: u = f_uop(OP_MUL,  SL_EX,  SL_FX,  3'd2, 3'd2, 1'b1, 1'b1);
            6'd36: u = f_uop(OP_MUL,  SL_EY,  SL_FY,  3'd2, 3'd2, 1'b0, 1'b1);
            6'd37: u = f_uop(OP_ST,   SL_P,   SL_P,   3'd0, 3'd0, 1'b0, 1'b0);
            6'd38: u = f_uop(OP_MUL,  SL_N1,  SL_N2,  3'd3, 3'd3, 1'b1, 1'b0);
            6'd39: u = f_uop(OP_ST,   SL_Q,   SL_Q,   3'd0, 3'd0, 1'b0, 1'b0);
            6'd40: u = f_uop(OP_MUL,  SL_CL,  SL_CL,  3'd1, 3'd1, 1'b1, 1'b0);
            6'd41: u = f_uop(OP_ST,   SL_L2,  SL_L2,  3'd0, 3'd0, 1'b0, 1'b0);
            6'd42: u = f_uop(OP_MUL,  SL_L2,  SL_Q,   3'd1, 3'd5, 1'b1, 1'b0);
            6'd43: u = f_uop(OP_ST,   SL_RHS, SL_RHS, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd44: u = f_uop(OP_MUL,  SL_P,   SL_P,   3'd3, 3'd3, 1'b1, 1'b0);
            6'd45: u = f_uop(OP_STSH, SL_LHS, SL_LHS, 3'd0, 3'd0, 1'b0, 1'b0);
            6'd46: u = f_uop(OP_PSIG, SL_P,   SL_P,   3'd0, 3'd0, 1'b0, 1'b0);
            6'd47: u = f_uop(OP_COS,  SL_LHS, SL_RHS, 3'd0, 3'd0, 1'b0, 1'b0);
            default: u = f_uop(OP_COS, SL_LHS, SL_RHS, 3'd0, 3'd0, 1'b0, 1'b0);
        endcase
        return u;
    endfunction

endpackage

[hw/rtl/pvr_in_if.sv]
// Vertex input channel: valid/ready handshake with the vertex payload.
interface pvr_in_if;
    import pvr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [C_ID_W-1:0]    point_id;
    logic signed [C_COORD_W-1:0] x_coord;
    logic signed [C_COORD_W-1:0] y_coord;
    logic                 end_of_line;

    modport source (output valid, point_id, x_coord, y_coord, end_of_line, input ready);
    modport sink   (input valid, point_id, x_coord, y_coord, end_of_line, output ready);
endinterface

[hw/rtl/pvr_out_if.sv]
// Kept-vertex output channel: valid/ready handshake with the result payload.
interface pvr_out_if;
    import pvr_pkg::*;

    logic              valid;
    logic              ready;
    logic [C_ID_W-1:0] kept_id;
    logic              last_kept;

    modport source (output valid, kept_id, last_kept, input ready);
    modport sink   (input valid, kept_id, last_kept, output ready);
endinterface

[hw/rtl/pvr_slot_ram.sv]
// Slot memory for intermediate wide values: one write port, two registered read ports.
module pvr_slot_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  pvr_pkg::t_slot                i_waddr,
    input  logic [pvr_pkg::C_WIDE_W-1:0]  i_wdata,
    input  pvr_pkg::t_slot                i_raddr_a,
    input  pvr_pkg::t_slot                i_raddr_b,
    output logic [pvr_pkg::C_WIDE_W-1:0]  o_rdata_a,
    output logic [pvr_pkg::C_WIDE_W-1:0]  o_rdata_b
);
    import pvr_pkg::*;

    logic [C_WIDE_W-1:0] r_mem [C_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

[hw/rtl/pvr_mac.sv]
// Shared limb multiplier with a registered product and a wide accumulator.
module pvr_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pvr_pkg::t_mac_ctrl           i_ctrl,
    output logic [pvr_pkg::C_WIDE_W-1:0] o_acc
);
    import pvr_pkg::*;

    logic [2*C_LIMB_W-1:0] r_prod;
    logic [2:0]            r_pos;
    logic                  r_psub;
    logic                  r_pv;
    logic [C_WIDE_W-1:0]   r_acc;
    logic [C_WIDE_W-1:0]   s_term;
    logic [C_LIMB_SH+2:0]  s_shamt;

    assign s_shamt = {r_pos, {C_LIMB_SH{1'b0}}};
    assign s_term  = C_WIDE_W'(r_prod) << s_shamt;
    assign o_acc   = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctrl.mul;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_ctrl.a * i_ctrl.b;
        r_pos  <= i_ctrl.pos;
        r_psub <= i_ctrl.sub;
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_psub ? (r_acc - s_term) : (r_acc + s_term);
        end
    end
endmodule

[hw/rtl/pvr_seq.sv]
// Micro-programmed sequencer running the removal tests on the shared limb multiplier.
module pvr_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  pvr_pkg::t_geom                 i_geom,
    input  logic [pvr_pkg::C_THR_W-1:0]    i_thr,
    input  logic [pvr_pkg::C_COS_W-1:0]    i_cos,
    output pvr_pkg::t_seq_stat             o_stat
);
    import pvr_pkg::*;

    t_seq_state r_sq, n_sq;
    logic [C_PC_W-1:0] r_pc, n_pc;
    logic [2:0] r_i, n_i, r_j, n_j;
    logic [C_MAG_LIMBS-1:0][C_LIMB_W-1:0] r_ma, n_ma, r_mb, n_mb;
    logic r_neg, n_neg, r_p_neg, n_p_neg, r_p_zero, n_p_zero;

    t_uop s_uop;
    logic s_we;
    logic [C_WIDE_W-1:0] s_wdata, s_ldin, s_rda, s_rdb, s_acc;
    t_mac_ctrl s_mac;
    logic s_le, s_ge, s_rem;

    function automatic logic [C_WIDE_W-1:0] f_diff(logic [C_COORD_W-1:0] a,
                                                  logic [C_COORD_W-1:0] b);
        logic [C_DIFF_W-1:0] d;
        d = {a[C_COORD_W-1], a} - {b[C_COORD_W-1], b};
        return {{(C_WIDE_W-C_DIFF_W){d[C_DIFF_W-1]}}, d};
    endfunction

    function automatic logic [C_MAG_W-1:0] f_mag(logic [C_WIDE_W-1:0] v);
        logic [C_WIDE_W-1:0] m;
        m = v[C_WIDE_W-1] ? (~v + 1'b1) : v;
        return m[C_MAG_W-1:0];
    endfunction

    assign s_uop = f_prog(r_pc);
    assign s_le  = $signed(s_rda) <= $signed(s_rdb);
    assign s_ge  = $signed(s_rda) >= $signed(s_rdb);

    always_comb begin
        if (!i_cos[C_COS_W-1]) begin
            s_rem = (r_p_neg || r_p_zero) ? 1'b1 : s_le;
        end else begin
            s_rem = r_p_neg ? s_ge : 1'b0;
        end
    end

    always_comb begin
        case (s_uop.a)
            SL_DX:   s_ldin = f_diff(i_geom.bx, i_geom.ax);
            SL_DY:   s_ldin = f_diff(i_geom.by, i_geom.ay);
            SL_EX:   s_ldin = f_diff(i_geom.cx, i_geom.ax);
            SL_EY:   s_ldin = f_diff(i_geom.cy, i_geom.ay);
            SL_FX:   s_ldin = f_diff(i_geom.bx, i_geom.cx);
            SL_FY:   s_ldin = f_diff(i_geom.by, i_geom.cy);
            SL_THR:  s_ldin = {{(C_WIDE_W-C_THR_W){1'b0}}, i_thr};
            SL_CL:   s_ldin = {{(C_WIDE_W-C_COS_W){i_cos[C_COS_W-1]}}, i_cos};
            default: s_ldin = '0;
        endcase
    end

    pvr_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (s_we),
        .i_waddr   (s_uop.a),
        .i_wdata   (s_wdata),
        .i_raddr_a (s_uop.a),
        .i_raddr_b (s_uop.b),
        .o_rdata_a (s_rda),
        .o_rdata_b (s_rdb)
    );

    pvr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (s_mac),
        .o_acc   (s_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= SQ_IDLE;
        end else begin
            r_sq <= n_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc     <= n_pc;
        r_i      <= n_i;
        r_j      <= n_j;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_neg    <= n_neg;
        r_p_neg  <= n_p_neg;
        r_p_zero <= n_p_zero;
    end

    always_comb begin
        n_sq     = r_sq;
        n_pc     = r_pc;
        n_i      = r_i;
        n_j      = r_j;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_neg    = r_neg;
        n_p_neg  = r_p_neg;
        n_p_zero = r_p_zero;
        s_we     = 1'b0;
        s_wdata  = s_ldin;
        s_mac    = '0;
        o_stat   = '0;
        case (r_sq)
            SQ_IDLE: begin
                if (i_start) begin
                    n_pc = '0;
                    n_sq = SQ_FETCH;
                end
            end
            SQ_FETCH: begin
                case (s_uop.op)
                    OP_LDIN: begin
                        s_we = 1'b1;
                        n_pc = r_pc + 1'b1;
                    end
                    OP_ST: begin
                        s_we    = 1'b1;
                        s_wdata = s_acc;
                        n_pc    = r_pc + 1'b1;
                    end
                    OP_STSH: begin
                        s_we    = 1'b1;
                        s_wdata = s_acc << C_LHS_SH;
                        n_pc    = r_pc + 1'b1;
                    end
                    default: n_sq = SQ_EXEC;
                endcase
            end
            SQ_EXEC: begin
                case (s_uop.op)
                    OP_MUL: begin
                        n_ma      = f_mag(s_rda);
                        n_mb      = f_mag(s_rdb);
                        n_neg     = s_rda[C_WIDE_W-1] ^ s_rdb[C_WIDE_W-1] ^ s_uop.sub;
                        s_mac.clr = s_uop.clr;
                        n_i       = '0;
                        n_j       = '0;
                        n_sq      = SQ_LIMB;
                    end
                    OP_ZERO, OP_NEG, OP_GT: begin
                        // drop the candidate test chain as soon as one test keeps it
                        if ((s_uop.op == OP_ZERO && s_rda == '0) ||
                            (s_uop.op == OP_NEG && s_rda[C_WIDE_W-1]) ||
                            (s_uop.op == OP_GT && !s_le)) begin
                            o_stat.done = 1'b1;
                            o_stat.keep = 1'b1;
                            n_sq        = SQ_IDLE;
                        end else begin
                            n_pc = r_pc + 1'b1;
                            n_sq = SQ_FETCH;
                        end
                    end
                    OP_PSIG: begin
                        n_p_neg  = s_rda[C_WIDE_W-1];
                        n_p_zero = (s_rda == '0);
                        n_pc     = r_pc + 1'b1;
                        n_sq     = SQ_FETCH;
                    end
                    default: begin
                        o_stat.done = 1'b1;
                        o_stat.keep = !s_rem;
                        n_sq        = SQ_IDLE;
                    end
                endcase
            end
            SQ_LIMB: begin
                s_mac.mul = 1'b1;
                s_mac.sub = r_neg;
                s_mac.a   = r_ma[r_i];
                s_mac.b   = r_mb[r_j];
                s_mac.pos = r_i + r_j;
                if (r_j == s_uop.nb - 3'd1) begin
                    n_j = '0;
                    if (r_i == s_uop.na - 3'd1) begin
                        n_sq = SQ_DRAIN;
                    end else begin
                        n_i = r_i + 3'd1;
                    end
                end else begin
                    n_j = r_j + 3'd1;
                end
            end
            SQ_DRAIN: begin
                n_pc = r_pc + 1'b1;
                n_sq = SQ_FETCH;
            end
            default: n_sq = SQ_IDLE;
        endcase
    end
endmodule

[hw/rtl/polyline_vertex_reducer.sv]
// Top level of the polyline vertex reducer: stream control, vertex state and result queue.
//
// Vertices of a polyline arrive on i_in (point_id, Q16.16 x_coord/y_coord, end_of_line);
// the ids of kept vertices leave on o_out (kept_id, last_kept). A transfer happens on
// any clock edge with valid and ready both high. i_cfg_we writes dist_threshold
// (index CFG_DIST) or cos_limit (index CFG_COS) from i_cfg_data; write only while idle.
// The first vertex of a line, and a vertex with no pending candidate, skip evaluation;
// i_in is ready again once any pending results are pushed. A vertex that tests a candidate
// runs the micro-program on the single 32x32 limb multiplier and finishes sooner
// when an early test already keeps the candidate. Each wide product is built pair by
// pair of 32-bit limbs, after a slot read and a magnitude step and before a drain step.
// Results enter a two-entry queue, so a stalled receiver does not stop the next vertex
// being taken; the block only waits when the queue is full with results still to push.
// Synchronous reset clears the line state, the queue and the sequencer, and reloads
// dist_threshold = 1.0 and cos_limit = -32276.
`include "polyline_vertex_reducer_defines.svh"
module polyline_vertex_reducer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pvr_in_if.sink                          i_in,
    pvr_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [pvr_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pvr_pkg::C_CFG_W-1:0]     i_cfg_data
);
    import pvr_pkg::*;

    t_state r_state, n_state;

    logic [C_THR_W-1:0]   r_dist;
    logic [C_COS_W-1:0]   r_cos;

    logic [C_COORD_W-1:0] r_anc_x, r_anc_y, r_cand_x, r_cand_y, r_new_x, r_new_y;
    logic                 r_anc_v, r_cand_v, r_new_eol;
    logic [C_ID_W-1:0]    r_cand_id, r_new_id, r_pid_cand;

    logic                 r_pend_cand, r_pend_new, r_pnew_last;

    logic [C_ID_W-1:0]    r_q_id [2];
    logic                 r_q_last [2];
    logic                 r_q_rd, r_q_wr;
    logic [1:0]           r_q_cnt;

    logic      s_in_xfer, s_out_xfer, s_start, s_q_full;
    logic      s_push_cand, s_push_new, s_push, s_eval_done;
    logic [C_ID_W-1:0] s_push_id;
    logic      s_push_last;
    t_geom     s_geom;
    t_seq_stat s_stat;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign s_in_xfer   = i_in.valid && i_in.ready;
    assign s_out_xfer  = o_out.valid && o_out.ready;
    assign s_start     = s_in_xfer && r_anc_v && r_cand_v;
    assign s_eval_done = (r_state == ST_EVAL) && s_stat.done;
    assign s_q_full    = (r_q_cnt == 2'd2);

    assign o_out.valid     = (r_q_cnt != 2'd0);
    assign o_out.kept_id   = r_q_id[r_q_rd];
    assign o_out.last_kept = r_q_last[r_q_rd];

    assign s_geom = '{ax: r_anc_x, ay: r_anc_y, cx: r_cand_x, cy: r_cand_y,
                      bx: r_new_x, by: r_new_y};

    pvr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_geom  (s_geom),
        .i_thr   (r_dist),
        .i_cos   (r_cos),
        .o_stat  (s_stat)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and push control: the candidate goes out before the new vertex
    always_comb begin
        n_state     = r_state;
        s_push_cand = 1'b0;
        s_push_new  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_in_xfer) begin
                    n_state = (r_anc_v && r_cand_v) ? ST_EVAL : ST_EMIT;
                end
            end
            ST_EVAL: begin
                if (s_stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_pend_cand && !r_pend_new) begin
                    n_state = ST_IDLE;
                end else if (!s_q_full) begin
                    s_push_cand = r_pend_cand;
                    s_push_new  = !r_pend_cand;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign s_push      = s_push_cand || s_push_new;
    assign s_push_id   = s_push_cand ? r_pid_cand : r_new_id;
    assign s_push_last = s_push_cand ? 1'b0 : r_pnew_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= C_DIST_RST;
            r_cos  <= C_COS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIST: r_dist <= i_cfg_data[C_THR_W-1:0];
                CFG_COS:  r_cos  <= i_cfg_data[C_COS_W-1:0];
                default:  r_dist <= r_dist;
            endcase
        end
    end

    // line control: anchor, candidate and pending results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anc_v     <= 1'b0;
            r_cand_v    <= 1'b0;
            r_pend_cand <= 1'b0;
            r_pend_new  <= 1'b0;
        end else begin
            if (s_in_xfer) begin
                if (!r_anc_v) begin
                    // first vertex: emit at once, hold as anchor unless the line ends
                    r_pend_new <= 1'b1;
                    r_anc_v    <= !i_in.end_of_line;
                    r_cand_v   <= 1'b0;
                end else if (!r_cand_v) begin
                    r_pend_new <= i_in.end_of_line;
                    r_anc_v    <= !i_in.end_of_line;
                    r_cand_v   <= !i_in.end_of_line;
                end
            end else if (s_eval_done) begin
                r_pend_cand <= s_stat.keep;
                r_pend_new  <= r_new_eol;
                r_anc_v     <= !r_new_eol;
                r_cand_v    <= !r_new_eol;
            end else begin
                if (s_push_cand) begin
                    r_pend_cand <= 1'b0;
                end
                if (s_push_new) begin
                    r_pend_new <= 1'b0;
                end
            end
        end
    end

    // vertex payload registers
    always_ff @(posedge i_clk) begin
        if (s_in_xfer) begin
            r_new_id  <= i_in.point_id;
            r_new_x   <= i_in.x_coord;
            r_new_y   <= i_in.y_coord;
            r_new_eol <= i_in.end_of_line;
            if (!r_anc_v) begin
                r_anc_x     <= i_in.x_coord;
                r_anc_y     <= i_in.y_coord;
                r_pnew_last <= i_in.end_of_line;
            end else if (!r_cand_v) begin
                r_pnew_last <= 1'b1;
                r_cand_id   <= i_in.point_id;
                r_cand_x    <= i_in.x_coord;
                r_cand_y    <= i_in.y_coord;
            end
        end else if (s_eval_done) begin
            r_pid_cand  <= r_cand_id;
            r_pnew_last <= 1'b1;
            if (s_stat.keep) begin
                r_anc_x <= r_cand_x;
                r_anc_y <= r_cand_y;
            end
            r_cand_id <= r_new_id;
            r_cand_x  <= r_new_x;
            r_cand_y  <= r_new_y;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_rd  <= 1'b0;
            r_q_wr  <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            if (s_push) begin
                r_q_wr <= !r_q_wr;
            end
            if (s_out_xfer) begin
                r_q_rd <= !r_q_rd;
            end
            r_q_cnt <= r_q_cnt + {1'b0, s_push} - {1'b0, s_out_xfer};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_q_id[r_q_wr]   <= s_push_id;
            r_q_last[r_q_wr] <= s_push_last;
        end
    end

    `PVR_ASSERT_IMP(a_done_only_in_eval, s_stat.done, r_state == ST_EVAL)
    `PVR_ASSERT_NXT(a_xfer_leaves_idle, s_in_xfer, r_state != ST_IDLE)
    `PVR_ASSERT_NXT(a_keep_sets_pending, s_eval_done && s_stat.keep, r_pend_cand)
    `PVR_ASSERT_IMP(a_no_push_when_full, s_push, r_q_cnt != 2'd2)
endmodule
